FILE: src/pmsm_pkg.sv
`timescale 1ns / 1ps
package pmsm_pkg;

    localparam int SUBSTEPS = 4;

    // config reset values and minimums
    localparam logic [30:0] RST_MAGNET_FLUX = 31'd2684355;
    localparam logic [30:0] RST_RESISTANCE  = 31'd65536;
    localparam logic [30:0] RST_INDUCTANCE  = 31'd268435;
    localparam logic [7:0]  RST_POLE_PAIRS  = 8'd1;
    localparam logic [30:0] RST_DROP_GAIN   = 31'd45875;
    localparam logic [30:0] RST_DROP_KNEE   = 31'd2621;
    localparam logic [31:0] RST_STEP_PERIOD = 32'd858993;

    localparam logic [30:0] MIN_MAGNET_FLUX = 31'd2684355;
    localparam logic [30:0] MIN_RESISTANCE  = 31'd655;
    localparam logic [30:0] MIN_INDUCTANCE  = 31'd26844;

    // register indexes
    localparam logic [2:0] REG_MAGNET_FLUX = 3'd0;
    localparam logic [2:0] REG_RESISTANCE  = 3'd1;
    localparam logic [2:0] REG_D_IND       = 3'd2;
    localparam logic [2:0] REG_Q_IND       = 3'd3;
    localparam logic [2:0] REG_POLE_PAIRS  = 3'd4;
    localparam logic [2:0] REG_DROP_GAIN   = 3'd5;
    localparam logic [2:0] REG_DROP_KNEE   = 3'd6;
    localparam logic [2:0] REG_STEP_PERIOD = 3'd7;

    // datapath operations
    localparam int OPW = 6;
    localparam logic [OPW-1:0] OP_NONE    = 6'd0;
    localparam logic [OPW-1:0] OP_LOAD    = 6'd1;
    localparam logic [OPW-1:0] OP_M_VEL   = 6'd2;
    localparam logic [OPW-1:0] OP_W_VEL   = 6'd3;
    localparam logic [OPW-1:0] OP_M_PSID  = 6'd4;
    localparam logic [OPW-1:0] OP_W_PSID  = 6'd5;
    localparam logic [OPW-1:0] OP_M_PSIQ  = 6'd6;
    localparam logic [OPW-1:0] OP_W_PSIQ  = 6'd7;
    localparam logic [OPW-1:0] OP_M_EMFD  = 6'd8;
    localparam logic [OPW-1:0] OP_W_EMFD  = 6'd9;
    localparam logic [OPW-1:0] OP_M_EMFQ  = 6'd10;
    localparam logic [OPW-1:0] OP_W_EMFQ  = 6'd11;
    localparam logic [OPW-1:0] OP_M_DRPD  = 6'd12;
    localparam logic [OPW-1:0] OP_M_DRPQ  = 6'd13;
    localparam logic [OPW-1:0] OP_DIV_DRP = 6'd14;
    localparam logic [OPW-1:0] OP_W_DRPD  = 6'd15;
    localparam logic [OPW-1:0] OP_W_DRPQ  = 6'd16;
    localparam logic [OPW-1:0] OP_W_UE    = 6'd17;
    localparam logic [OPW-1:0] OP_M_RD    = 6'd18;
    localparam logic [OPW-1:0] OP_W_ND    = 6'd19;
    localparam logic [OPW-1:0] OP_M_RQ    = 6'd20;
    localparam logic [OPW-1:0] OP_W_NQ    = 6'd21;
    localparam logic [OPW-1:0] OP_M_ED    = 6'd22;
    localparam logic [OPW-1:0] OP_M_EQ    = 6'd23;
    localparam logic [OPW-1:0] OP_DIV_ED  = 6'd24;
    localparam logic [OPW-1:0] OP_DIV_EQ  = 6'd25;
    localparam logic [OPW-1:0] OP_W_ED    = 6'd26;
    localparam logic [OPW-1:0] OP_W_EQ    = 6'd27;
    localparam logic [OPW-1:0] OP_M_PT    = 6'd28;
    localparam logic [OPW-1:0] OP_W_PT    = 6'd29;
    localparam logic [OPW-1:0] OP_M_BASE  = 6'd30;
    localparam logic [OPW-1:0] OP_W_BASE  = 6'd31;
    localparam logic [OPW-1:0] OP_M_TQ    = 6'd32;
    localparam logic [OPW-1:0] OP_W_TQ    = 6'd33;
    localparam logic [OPW-1:0] OP_OUT     = 6'd34;

    // program layout
    localparam int PCW = 6;
    localparam logic [PCW-1:0] P_LOOP     = 6'd17;
    localparam logic [PCW-1:0] P_LOOP_END = 6'd26;
    localparam logic [PCW-1:0] P_LAST     = 6'd32;

    typedef struct packed {
        logic [OPW-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

    function automatic logic [OPW-1:0] prog(input logic [PCW-1:0] pc);
        logic [OPW-1:0] op;
        unique case (pc)
            6'd0:  op = OP_M_VEL;
            6'd1:  op = OP_W_VEL;
            6'd2:  op = OP_M_PSID;
            6'd3:  op = OP_W_PSID;
            6'd4:  op = OP_M_PSIQ;
            6'd5:  op = OP_W_PSIQ;
            6'd6:  op = OP_M_EMFD;
            6'd7:  op = OP_W_EMFD;
            6'd8:  op = OP_M_EMFQ;
            6'd9:  op = OP_W_EMFQ;
            6'd10: op = OP_M_DRPD;
            6'd11: op = OP_DIV_DRP;
            6'd12: op = OP_W_DRPD;
            6'd13: op = OP_M_DRPQ;
            6'd14: op = OP_DIV_DRP;
            6'd15: op = OP_W_DRPQ;
            6'd16: op = OP_W_UE;
            6'd17: op = OP_M_RD;
            6'd18: op = OP_W_ND;
            6'd19: op = OP_M_RQ;
            6'd20: op = OP_W_NQ;
            6'd21: op = OP_M_ED;
            6'd22: op = OP_DIV_ED;
            6'd23: op = OP_W_ED;
            6'd24: op = OP_M_EQ;
            6'd25: op = OP_DIV_EQ;
            6'd26: op = OP_W_EQ;
            6'd27: op = OP_M_PT;
            6'd28: op = OP_W_PT;
            6'd29: op = OP_M_BASE;
            6'd30: op = OP_W_BASE;
            6'd31: op = OP_M_TQ;
            6'd32: op = OP_W_TQ;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic is_div(input logic [OPW-1:0] op);
        return (op == OP_DIV_DRP) || (op == OP_DIV_ED) || (op == OP_DIV_EQ);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        logic [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/pmsm_div.sv
`timescale 1ns / 1ps
module pmsm_div #(
    parameter int NW = 64,
    parameter int DW = 39
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quot,
    output logic          o_done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NW-2:0], ge};
            r_rem <= ge ? DW'(rem_sh - {1'b0, r_div}) : rem_sh[DW-1:0];
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;
endmodule

FILE: src/pmsm_dp.sv
`timescale 1ns / 1ps
module pmsm_dp #(
    parameter int SUBSTEPS = pmsm_pkg::SUBSTEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pmsm_pkg::t_cmd      i_cmd,
    output pmsm_pkg::t_sts      o_sts,
    input  logic [30:0]         i_magnet_flux,
    input  logic [30:0]         i_winding_resistance,
    input  logic [30:0]         i_d_inductance,
    input  logic [30:0]         i_q_inductance,
    input  logic [7:0]          i_pole_pairs,
    input  logic [30:0]         i_drop_gain,
    input  logic [30:0]         i_drop_knee,
    input  logic [31:0]         i_step_period,
    input  logic signed [31:0]  i_mech_velocity,
    input  logic signed [31:0]  i_volt_d,
    input  logic signed [31:0]  i_volt_q,
    output logic signed [31:0]  o_cur_d,
    output logic signed [31:0]  o_cur_q,
    output logic signed [31:0]  o_flux_d,
    output logic signed [31:0]  o_flux_q,
    output logic signed [31:0]  o_emf_d,
    output logic signed [31:0]  o_emf_q,
    output logic signed [31:0]  o_drop_volt_d,
    output logic signed [31:0]  o_drop_volt_q,
    output logic signed [31:0]  o_motor_torque
);
    localparam int K   = SUBSTEPS * 16;
    localparam int KW  = $clog2(K + 1);
    localparam int DVW = 31 + KW;

    logic [pmsm_pkg::OPW-1:0] op;

    // clamped config, latched per item
    logic [30:0] r_psim, r_res, r_ld, r_lq, r_gain, r_knee;
    logic [7:0]  r_pp;
    logic [31:0] r_per;
    logic signed [31:0] r_vel, r_ud, r_uq;

    // working values; r_id and r_iq are the model state
    logic signed [31:0] r_id, r_iq, r_vel_e, r_psid, r_psiq, r_emfd, r_emfq;
    logic signed [31:0] r_drpd, r_drpq, r_ued, r_ueq, r_nd, r_nq, r_ptot, r_tq;
    logic signed [32:0] r_base;
    logic signed [65:0] r_prod;

    logic signed [32:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [67:0] prod_x;
    logic signed [67:0] sh16, sh28, sh1;

    logic               div_start;
    logic [DVW-1:0]     div_den;
    logic [63:0]        quot;
    logic               div_done;

    logic signed [32:0] id_x, iq_x, knee_x;
    logic [32:0]        qclamp;
    logic signed [33:0] step_d;
    logic signed [31:0] drop_sel_d, drop_sel_q;

    assign op = i_cmd.op;

    function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
        logic signed [32:0] x;
        x = {v[31], v};
        return v[31] ? -x : x;
    endfunction

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (op)
            pmsm_pkg::OP_M_VEL: begin
                mul_a = {r_vel[31], r_vel};
                mul_b = {25'd0, r_pp};
            end
            pmsm_pkg::OP_M_PSID: begin
                mul_a = {2'b0, r_ld};
                mul_b = {r_id[31], r_id};
            end
            pmsm_pkg::OP_M_PSIQ: begin
                mul_a = {2'b0, r_lq};
                mul_b = {r_iq[31], r_iq};
            end
            pmsm_pkg::OP_M_EMFD: begin
                mul_a = {r_vel_e[31], r_vel_e};
                mul_b = {r_psiq[31], r_psiq};
            end
            pmsm_pkg::OP_M_EMFQ: begin
                mul_a = {r_vel_e[31], r_vel_e};
                mul_b = {r_psid[31], r_psid};
            end
            pmsm_pkg::OP_M_DRPD: begin
                mul_a = {2'b0, r_gain};
                mul_b = abs33(r_id);
            end
            pmsm_pkg::OP_M_DRPQ: begin
                mul_a = {2'b0, r_gain};
                mul_b = abs33(r_iq);
            end
            pmsm_pkg::OP_M_RD: begin
                mul_a = {2'b0, r_res};
                mul_b = {r_id[31], r_id};
            end
            pmsm_pkg::OP_M_RQ: begin
                mul_a = {2'b0, r_res};
                mul_b = {r_iq[31], r_iq};
            end
            pmsm_pkg::OP_M_ED: begin
                mul_a = abs33(r_nd);
                mul_b = {1'b0, r_per};
            end
            pmsm_pkg::OP_M_EQ: begin
                mul_a = abs33(r_nq);
                mul_b = {1'b0, r_per};
            end
            pmsm_pkg::OP_M_PT: begin
                mul_a = $signed({2'b0, r_ld}) - $signed({2'b0, r_lq});
                mul_b = {r_id[31], r_id};
            end
            pmsm_pkg::OP_M_BASE: begin
                mul_a = {r_ptot[31], r_ptot};
                mul_b = {r_iq[31], r_iq};
            end
            pmsm_pkg::OP_M_TQ: begin
                mul_a = r_base;
                mul_b = {23'd0, 10'({2'b0, r_pp} + {1'b0, r_pp, 1'b0})};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign prod_x = {{2{r_prod[65]}}, r_prod};
    assign sh16   = prod_x >>> 16;
    assign sh28   = prod_x >>> 28;
    assign sh1    = prod_x >>> 1;

    // divisor: drop knee, or inductance times substeps times 16
    assign div_start = pmsm_pkg::is_div(op);
    always_comb begin
        unique case (op)
            pmsm_pkg::OP_DIV_ED: div_den = DVW'(r_ld) * DVW'(K);
            pmsm_pkg::OP_DIV_EQ: div_den = DVW'(r_lq) * DVW'(K);
            default:             div_den = DVW'(r_knee);
        endcase
    end

    pmsm_div #(.NW(64), .DW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[63:0]),
        .i_divisor  (div_den),
        .o_quot     (quot),
        .o_done     (div_done)
    );
    assign o_sts.div_done = div_done;

    assign id_x   = {r_id[31], r_id};
    assign iq_x   = {r_iq[31], r_iq};
    assign knee_x = {2'b0, r_knee};
    assign qclamp = (quot > 64'h1_0000_0000) ? 33'h1_0000_0000 : quot[32:0];

    always_comb begin
        if (op == pmsm_pkg::OP_W_ED) begin
            step_d = r_nd[31] ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
        end else begin
            step_d = r_nq[31] ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
        end
    end

    // saturating drop: full gain outside the knee, scaled inside
    always_comb begin
        if (id_x <= -knee_x) begin
            drop_sel_d = 32'(-$signed({1'b0, r_gain}));
        end else if (id_x >= knee_x) begin
            drop_sel_d = {1'b0, r_gain};
        end else begin
            drop_sel_d = r_id[31] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
        end
        if (iq_x <= -knee_x) begin
            drop_sel_q = 32'(-$signed({1'b0, r_gain}));
        end else if (iq_x >= knee_x) begin
            drop_sel_q = {1'b0, r_gain};
        end else begin
            drop_sel_q = r_iq[31] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= '0;
            r_iq <= '0;
        end else begin
            unique case (op)
                pmsm_pkg::OP_W_ED: r_id <= pmsm_pkg::sat32(68'(id_x) + 68'(step_d));
                pmsm_pkg::OP_W_EQ: r_iq <= pmsm_pkg::sat32(68'(iq_x) + 68'(step_d));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (op)
            pmsm_pkg::OP_LOAD: begin
                r_psim <= (i_magnet_flux < pmsm_pkg::MIN_MAGNET_FLUX)
                          ? pmsm_pkg::MIN_MAGNET_FLUX : i_magnet_flux;
                r_res  <= (i_winding_resistance < pmsm_pkg::MIN_RESISTANCE)
                          ? pmsm_pkg::MIN_RESISTANCE : i_winding_resistance;
                r_ld   <= (i_d_inductance < pmsm_pkg::MIN_INDUCTANCE)
                          ? pmsm_pkg::MIN_INDUCTANCE : i_d_inductance;
                r_lq   <= (i_q_inductance < pmsm_pkg::MIN_INDUCTANCE)
                          ? pmsm_pkg::MIN_INDUCTANCE : i_q_inductance;
                r_pp   <= (i_pole_pairs == '0) ? 8'd1 : i_pole_pairs;
                r_gain <= i_drop_gain;
                r_knee <= (i_drop_knee == '0) ? 31'd1 : i_drop_knee;
                r_per  <= (i_step_period == '0) ? 32'd1 : i_step_period;
                r_vel  <= i_mech_velocity;
                r_ud   <= i_volt_d;
                r_uq   <= i_volt_q;
            end
            pmsm_pkg::OP_W_VEL:  r_vel_e <= pmsm_pkg::sat32(prod_x);
            pmsm_pkg::OP_W_PSID: r_psid <= pmsm_pkg::sat32(sh16 + 68'(r_psim));
            pmsm_pkg::OP_W_PSIQ: r_psiq <= pmsm_pkg::sat32(sh16);
            pmsm_pkg::OP_W_EMFD: r_emfd <= pmsm_pkg::sat32(sh28);
            pmsm_pkg::OP_W_EMFQ: r_emfq <= pmsm_pkg::sat32(sh28);
            pmsm_pkg::OP_W_DRPD: r_drpd <= drop_sel_d;
            pmsm_pkg::OP_W_DRPQ: r_drpq <= drop_sel_q;
            pmsm_pkg::OP_W_UE: begin
                r_ued <= pmsm_pkg::sat32(68'(r_ud) - 68'(r_drpd));
                r_ueq <= pmsm_pkg::sat32(68'(r_uq) - 68'(r_drpq));
            end
            pmsm_pkg::OP_W_ND: r_nd <= pmsm_pkg::sat32(68'(r_ued) - sh16 + 68'(r_emfd));
            pmsm_pkg::OP_W_NQ: r_nq <= pmsm_pkg::sat32(68'(r_ueq) - sh16 - 68'(r_emfq));
            pmsm_pkg::OP_W_PT: r_ptot <= pmsm_pkg::sat32(68'(r_psim) + sh16);
            pmsm_pkg::OP_W_BASE: begin
                // beyond 33 bits the torque saturates either way
                if (sh28 > 68'sd4294967295) begin
                    r_base <= 33'h0_ffff_ffff;
                end else if (sh28 < -68'sd4294967296) begin
                    r_base <= 33'h1_0000_0000;
                end else begin
                    r_base <= sh28[32:0];
                end
            end
            pmsm_pkg::OP_W_TQ: r_tq <= pmsm_pkg::sat32(sh1);
            pmsm_pkg::OP_OUT: begin
                o_cur_d        <= r_id;
                o_cur_q        <= r_iq;
                o_flux_d       <= r_psid;
                o_flux_q       <= r_psiq;
                o_emf_d        <= r_emfd;
                o_emf_q        <= r_emfq;
                o_drop_volt_d  <= r_drpd;
                o_drop_volt_q  <= r_drpq;
                o_motor_torque <= r_tq;
            end
            default: ;
        endcase
    end
endmodule

FILE: src/pmsm_ctrl.sv
`timescale 1ns / 1ps
module pmsm_ctrl #(
    parameter int SUBSTEPS = pmsm_pkg::SUBSTEPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output pmsm_pkg::t_cmd o_cmd,
    input  pmsm_pkg::t_sts i_sts
);
    localparam int SW = $clog2(SUBSTEPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [pmsm_pkg::PCW-1:0] r_pc, n_pc;
    logic [SW-1:0]            r_sub, n_sub;
    logic                     r_ovalid, n_ovalid;
    logic [pmsm_pkg::OPW-1:0] op;
    logic                     out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_sub    = r_sub;
        n_ovalid = r_ovalid && i_stall;
        op       = pmsm_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    op      = pmsm_pkg::OP_LOAD;
                    n_pc    = '0;
                    n_sub   = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                op = pmsm_pkg::prog(r_pc);
                priority if (pmsm_pkg::is_div(op)) begin
                    n_state = S_WAIT;
                end else if (r_pc == pmsm_pkg::P_LOOP_END &&
                             r_sub != SW'(SUBSTEPS - 1)) begin
                    n_pc  = pmsm_pkg::P_LOOP;
                    n_sub = r_sub + 1'b1;
                end else if (r_pc == pmsm_pkg::P_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_RUN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    op       = pmsm_pkg::OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_sub    <= n_sub;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_cmd.op   = op;

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_RUN && r_pc == '0))
        else $error("accepted item did not start the program");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside a wait");
    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub < SW'(SUBSTEPS))
        else $error("substep count out of range");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && i_stall) |=> (r_state == S_FIN && r_ovalid))
        else $error("result overwritten while stalled");
endmodule

FILE: src/pmsm_dq_motor_model_step.sv
`timescale 1ns / 1ps
// pmsm d/q electrical model, one tick per item
// input channel: i_valid / o_stall carry mech_velocity, volt_d, volt_q;
//   an item is taken when i_valid is high and o_stall is low
// output channel: o_valid / i_stall carry currents, fluxes, emf terms,
//   drops and torque; a result is taken when o_valid is high and i_stall low
// one item is worked at a time on a shared 33x33 multiplier and a shared
//   restoring divider that retires one quotient bit per cycle
// each item runs two divisions for the drops and two per substep for the
//   current updates (ten at 4 substeps), and a new item is taken only after
//   the program of the last one has finished
// results land in an output register, so the next item is taken while a
//   result still waits; a stalled result holds, and the program parks in
//   its final step until the output register frees up
// reset clears both stored currents, the handshake state and loads the
//   config defaults; config goes through the apb port at byte address 4*i
module pmsm_dq_motor_model_step #(
    parameter int SUBSTEPS = pmsm_pkg::SUBSTEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_mech_velocity,
    input  logic signed [31:0] i_volt_d,
    input  logic signed [31:0] i_volt_q,
    // result items
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_cur_d,
    output logic signed [31:0] o_cur_q,
    output logic signed [31:0] o_flux_d,
    output logic signed [31:0] o_flux_q,
    output logic signed [31:0] o_emf_d,
    output logic signed [31:0] o_emf_q,
    output logic signed [31:0] o_drop_volt_d,
    output logic signed [31:0] o_drop_volt_q,
    output logic signed [31:0] o_motor_torque
);
    logic [30:0] r_magnet_flux, r_resistance, r_d_ind, r_q_ind;
    logic [30:0] r_drop_gain, r_drop_knee;
    logic [7:0]  r_pole_pairs;
    logic [31:0] r_step_period;
    logic        wr_en;
    logic [2:0]  reg_idx;

    pmsm_pkg::t_cmd cmd;
    pmsm_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // config registers, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magnet_flux <= pmsm_pkg::RST_MAGNET_FLUX;
            r_resistance  <= pmsm_pkg::RST_RESISTANCE;
            r_d_ind       <= pmsm_pkg::RST_INDUCTANCE;
            r_q_ind       <= pmsm_pkg::RST_INDUCTANCE;
            r_pole_pairs  <= pmsm_pkg::RST_POLE_PAIRS;
            r_drop_gain   <= pmsm_pkg::RST_DROP_GAIN;
            r_drop_knee   <= pmsm_pkg::RST_DROP_KNEE;
            r_step_period <= pmsm_pkg::RST_STEP_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                pmsm_pkg::REG_MAGNET_FLUX: r_magnet_flux <= pwdata[30:0];
                pmsm_pkg::REG_RESISTANCE:  r_resistance  <= pwdata[30:0];
                pmsm_pkg::REG_D_IND:       r_d_ind       <= pwdata[30:0];
                pmsm_pkg::REG_Q_IND:       r_q_ind       <= pwdata[30:0];
                pmsm_pkg::REG_POLE_PAIRS:  r_pole_pairs  <= pwdata[7:0];
                pmsm_pkg::REG_DROP_GAIN:   r_drop_gain   <= pwdata[30:0];
                pmsm_pkg::REG_DROP_KNEE:   r_drop_knee   <= pwdata[30:0];
                pmsm_pkg::REG_STEP_PERIOD: r_step_period <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            pmsm_pkg::REG_MAGNET_FLUX: prdata = {1'b0, r_magnet_flux};
            pmsm_pkg::REG_RESISTANCE:  prdata = {1'b0, r_resistance};
            pmsm_pkg::REG_D_IND:       prdata = {1'b0, r_d_ind};
            pmsm_pkg::REG_Q_IND:       prdata = {1'b0, r_q_ind};
            pmsm_pkg::REG_POLE_PAIRS:  prdata = {24'd0, r_pole_pairs};
            pmsm_pkg::REG_DROP_GAIN:   prdata = {1'b0, r_drop_gain};
            pmsm_pkg::REG_DROP_KNEE:   prdata = {1'b0, r_drop_knee};
            pmsm_pkg::REG_STEP_PERIOD: prdata = r_step_period;
            default:                   prdata = '0;
        endcase
    end

    // sequencer: walks the per-item program and the substep loop
    pmsm_ctrl #(.SUBSTEPS(SUBSTEPS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // arithmetic, stored currents and the output register
    pmsm_dp #(.SUBSTEPS(SUBSTEPS)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_magnet_flux        (r_magnet_flux),
        .i_winding_resistance (r_resistance),
        .i_d_inductance       (r_d_ind),
        .i_q_inductance       (r_q_ind),
        .i_pole_pairs         (r_pole_pairs),
        .i_drop_gain          (r_drop_gain),
        .i_drop_knee          (r_drop_knee),
        .i_step_period        (r_step_period),
        .i_mech_velocity      (i_mech_velocity),
        .i_volt_d             (i_volt_d),
        .i_volt_q             (i_volt_q),
        .o_cur_d              (o_cur_d),
        .o_cur_q              (o_cur_q),
        .o_flux_d             (o_flux_d),
        .o_flux_q             (o_flux_q),
        .o_emf_d              (o_emf_d),
        .o_emf_q              (o_emf_q),
        .o_drop_volt_d        (o_drop_volt_d),
        .o_drop_volt_q        (o_drop_volt_q),
        .o_motor_torque       (o_motor_torque)
    );
endmodule
